// ===== hdl/pyu_pkg.sv =====
`timescale 1ns / 1ps
package pyu_pkg;

    localparam int DEF_MAX_CLUSTERS     = 256;
    localparam int DEF_MAX_OBSERVATIONS = 65536;

    localparam int CMD_W    = 2;
    localparam int LABEL_W  = 8;
    localparam int UNI_W    = 16;
    localparam int CONC_W   = 24;
    localparam int DISC_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 24;

    typedef logic [CMD_W-1:0]    t_command;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [CFG_A_W-1:0]  t_cfg_addr;
    typedef logic [3:0]          t_op;
    typedef logic [1:0]          t_lsrc;

    localparam t_command CMD_CLEAR = 2'd0;
    localparam t_command CMD_SEED  = 2'd1;
    localparam t_command CMD_DRAW  = 2'd2;
    localparam t_command CMD_NOP   = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_BAD_LABEL = 2'd2;

    localparam t_cfg_addr REG_CONC = 1'd0;
    localparam t_cfg_addr REG_DISC = 1'd1;

    // datapath operations
    localparam t_op OP_NONE    = 4'd0;
    localparam t_op OP_LATCH   = 4'd1;
    localparam t_op OP_SWEEP   = 4'd2;
    localparam t_op OP_SEED_RD = 4'd3;
    localparam t_op OP_SEED_WR = 4'd4;
    localparam t_op OP_MUL_LO  = 4'd5;
    localparam t_op OP_MUL_HI  = 4'd6;
    localparam t_op OP_SCAN    = 4'd7;
    localparam t_op OP_HIT_WR  = 4'd8;
    localparam t_op OP_OPEN_WR = 4'd9;

    // source of the result label
    localparam t_lsrc LSRC_ZERO = 2'd0;
    localparam t_lsrc LSRC_SEED = 2'd1;
    localparam t_lsrc LSRC_HIT  = 2'd2;
    localparam t_lsrc LSRC_OPEN = 2'd3;

    typedef struct packed {
        t_op     op;
        logic    res_valid;
        t_lsrc   lsrc;
        logic    res_open;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic label_bad;
        logic obs_full;
        logic table_full;
        logic sweep_last;
        logic scan_hit;
        logic scan_end;
        logic found;
    } t_dp_sts;

endpackage

// ===== hdl/pyu_dp.sv =====
`timescale 1ns / 1ps
module pyu_dp import pyu_pkg::*; #(
    parameter int MAX_CLUSTERS     = DEF_MAX_CLUSTERS,
    parameter int MAX_OBSERVATIONS = DEF_MAX_OBSERVATIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [LABEL_W-1:0]  i_seed_label,
    input  logic [UNI_W-1:0]    i_uniform,
    input  logic                i_cfg_we,
    input  t_cfg_addr           i_cfg_addr,
    input  logic [CFG_D_W-1:0]  i_cfg_wdata,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic                o_done,
    output logic [LABEL_W-1:0]  o_drawn_label,
    output logic                o_opened_cluster,
    output t_status             o_status
);

    localparam int IDX_W  = $clog2(MAX_CLUSTERS);
    localparam int CT_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int OBS_W  = $clog2(MAX_OBSERVATIONS + 1);
    localparam int CNT_W  = OBS_W;
    localparam int MB_W   = (OBS_W > CONC_W) ? OBS_W : CONC_W;
    localparam int PROD_W = UNI_W + MB_W;
    // threshold kept in 2^-16 units: floor(u*(total*65536+theta) / 65536)
    localparam int THR_W  = OBS_W + 33;
    localparam int RUN_W  = $clog2(MAX_OBSERVATIONS + MAX_CLUSTERS + 1) + 17;
    localparam int CMP_W  = ((RUN_W > THR_W) ? RUN_W : THR_W) + 1;

    logic [CNT_W-1:0] r_mem [MAX_CLUSTERS];
    logic [CNT_W-1:0] r_rdata;

    logic [CONC_W-1:0]  r_conc;
    logic [DISC_W-1:0]  r_disc;
    logic [CT_W-1:0]    r_cluster_total;
    logic [OBS_W-1:0]   r_obs_total;
    logic [CT_W-1:0]    r_addr;
    logic               r_pend;
    logic               r_found;
    logic               r_done;

    logic [LABEL_W-1:0] r_label;
    logic [UNI_W-1:0]   r_u;
    logic [THR_W-1:0]   r_thr;
    logic signed [CMP_W-1:0] r_run;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [CNT_W-1:0]   r_hit_cnt;
    logic [LABEL_W-1:0] r_out_label;
    logic               r_out_open;
    t_status            r_out_status;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [IDX_W-1:0]        mem_raddr;
    logic [CNT_W-1:0]        mem_wdata;
    logic [IDX_W-1:0]        w_label_idx;
    logic [CT_W-1:0]         w_label_top;
    logic                    w_issue;
    logic                    w_hit;
    logic [MB_W-1:0]         w_mul_b;
    logic [PROD_W-1:0]       w_prod;
    logic signed [CMP_W-1:0] n_run;
    logic [LABEL_W-1:0]      n_out_label;

    assign w_label_idx = IDX_W'(r_label);
    assign w_label_top = CT_W'(r_label) + CT_W'(1);
    assign w_issue     = r_addr < r_cluster_total;

    assign w_mul_b = (i_cmd.op == OP_MUL_HI) ? MB_W'(r_obs_total) : MB_W'(r_conc);
    assign w_prod  = PROD_W'(r_u) * PROD_W'(w_mul_b);

    // running sum of count*65536 - discount
    assign n_run = r_run + $signed(CMP_W'({r_rdata, 16'h0000})) - $signed(CMP_W'(r_disc));
    assign w_hit = r_pend && (n_run > $signed(CMP_W'(r_thr)));

    always_comb begin
        o_sts.label_bad  = 32'(r_label) >= 32'(MAX_CLUSTERS);
        o_sts.obs_full   = r_obs_total == OBS_W'(MAX_OBSERVATIONS);
        o_sts.table_full = r_cluster_total == CT_W'(MAX_CLUSTERS);
        o_sts.sweep_last = r_addr == CT_W'(MAX_CLUSTERS - 1);
        o_sts.scan_hit   = w_hit;
        o_sts.scan_end   = !r_pend && !w_issue;
        o_sts.found      = r_found;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr[IDX_W-1:0];
        mem_raddr = r_addr[IDX_W-1:0];
        mem_wdata = '0;
        case (i_cmd.op)
            OP_SWEEP: begin
                mem_we = 1'b1;
            end
            OP_SEED_RD: begin
                mem_raddr = w_label_idx;
            end
            OP_SEED_WR: begin
                mem_we    = 1'b1;
                mem_waddr = w_label_idx;
                mem_wdata = r_rdata + CNT_W'(1);
            end
            OP_HIT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_hit_idx;
                mem_wdata = r_hit_cnt + CNT_W'(1);
            end
            OP_OPEN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cluster_total[IDX_W-1:0];
                mem_wdata = CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        unique case (i_cmd.lsrc)
            LSRC_ZERO: n_out_label = '0;
            LSRC_SEED: n_out_label = r_label;
            LSRC_HIT:  n_out_label = LABEL_W'(r_hit_idx);
            LSRC_OPEN: n_out_label = LABEL_W'(r_cluster_total);
            default:   n_out_label = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conc          <= CONC_W'(65536);
            r_disc          <= '0;
            r_cluster_total <= '0;
            r_obs_total     <= '0;
            r_addr          <= '0;
            r_pend          <= 1'b0;
            r_found         <= 1'b0;
            r_done          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_CONC: r_conc <= i_cfg_wdata;
                    REG_DISC: r_disc <= i_cfg_wdata[DISC_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (i_cmd.op)
                OP_LATCH: begin
                    r_addr <= '0;
                end
                OP_SWEEP: begin
                    r_addr          <= r_addr + CT_W'(1);
                    r_cluster_total <= '0;
                    r_obs_total     <= '0;
                end
                OP_SEED_WR: begin
                    r_obs_total <= r_obs_total + OBS_W'(1);
                    if (w_label_top > r_cluster_total) begin
                        r_cluster_total <= w_label_top;
                    end
                end
                OP_MUL_HI: begin
                    r_pend  <= 1'b0;
                    r_found <= 1'b0;
                end
                OP_SCAN: begin
                    r_pend <= w_issue;
                    if (w_issue) begin
                        r_addr <= r_addr + CT_W'(1);
                    end
                    if (w_hit) begin
                        r_found <= 1'b1;
                    end
                end
                OP_HIT_WR: begin
                    r_obs_total <= r_obs_total + OBS_W'(1);
                end
                OP_OPEN_WR: begin
                    r_obs_total     <= r_obs_total + OBS_W'(1);
                    r_cluster_total <= r_cluster_total + CT_W'(1);
                end
                default: begin
                end
            endcase
            r_done <= i_cmd.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_label <= i_seed_label;
                r_u     <= i_uniform;
            end
            OP_MUL_LO: begin
                r_thr <= THR_W'(w_prod >> 16);
            end
            OP_MUL_HI: begin
                // u*total is already in 2^-16 units
                r_thr <= r_thr + THR_W'(w_prod);
                r_run <= '0;
            end
            OP_SCAN: begin
                r_rd_idx <= r_addr[IDX_W-1:0];
                if (r_pend) begin
                    r_run <= n_run;
                end
                if (w_hit) begin
                    r_hit_idx <= r_rd_idx;
                    r_hit_cnt <= r_rdata;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.res_valid) begin
            r_out_label  <= n_out_label;
            r_out_open   <= i_cmd.res_open;
            r_out_status <= i_cmd.res_status;
        end
    end

    assign o_done           = r_done;
    assign o_drawn_label    = r_out_label;
    assign o_opened_cluster = r_out_open;
    assign o_status         = r_out_status;

endmodule

// ===== hdl/pyu_ctrl.sv =====
`timescale 1ns / 1ps
module pyu_ctrl import pyu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_command i_command,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SWEEP   = 3'd1;
    localparam logic [2:0] S_SEED    = 3'd2;
    localparam logic [2:0] S_SEED_WR = 3'd3;
    localparam logic [2:0] S_DRAW    = 3'd4;
    localparam logic [2:0] S_MUL_HI  = 3'd5;
    localparam logic [2:0] S_SCAN    = 3'd6;
    localparam logic [2:0] S_DRAW_WR = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_quiet;  // sweep after reset gives no result

    always_comb begin
        n_state          = r_state;
        o_cmd.op         = OP_NONE;
        o_cmd.res_valid  = 1'b0;
        o_cmd.lsrc       = LSRC_ZERO;
        o_cmd.res_open   = 1'b0;
        o_cmd.res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LATCH;
                    unique case (i_command)
                        CMD_CLEAR: n_state = S_SWEEP;
                        CMD_SEED:  n_state = S_SEED;
                        CMD_DRAW:  n_state = S_DRAW;
                        CMD_NOP:   o_cmd.res_valid = 1'b1;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.op = OP_SWEEP;
                if (i_sts.sweep_last) begin
                    o_cmd.res_valid = !r_quiet;
                    n_state         = S_IDLE;
                end
            end
            S_SEED: begin
                o_cmd.lsrc = LSRC_SEED;
                if (i_sts.label_bad) begin
                    o_cmd.res_valid  = 1'b1;
                    o_cmd.res_status = ST_BAD_LABEL;
                    n_state          = S_IDLE;
                end else if (i_sts.obs_full) begin
                    o_cmd.res_valid  = 1'b1;
                    o_cmd.res_status = ST_FULL;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.op = OP_SEED_RD;
                    n_state  = S_SEED_WR;
                end
            end
            S_SEED_WR: begin
                o_cmd.op        = OP_SEED_WR;
                o_cmd.lsrc      = LSRC_SEED;
                o_cmd.res_valid = 1'b1;
                n_state         = S_IDLE;
            end
            S_DRAW: begin
                if (i_sts.obs_full) begin
                    o_cmd.res_valid  = 1'b1;
                    o_cmd.res_status = ST_FULL;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.op = OP_MUL_LO;
                    n_state  = S_MUL_HI;
                end
            end
            S_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    n_state = S_DRAW_WR;
                end
            end
            S_DRAW_WR: begin
                o_cmd.res_valid = 1'b1;
                n_state         = S_IDLE;
                if (i_sts.found) begin
                    o_cmd.op   = OP_HIT_WR;
                    o_cmd.lsrc = LSRC_HIT;
                end else if (i_sts.table_full) begin
                    o_cmd.res_status = ST_FULL;
                end else begin
                    o_cmd.op       = OP_OPEN_WR;
                    o_cmd.lsrc     = LSRC_OPEN;
                    o_cmd.res_open = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_quiet <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP && i_sts.sweep_last) begin
                r_quiet <= 1'b0;
            end
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

// ===== hdl/pitman_yor_urn_sampler.sv =====
`timescale 1ns / 1ps
// One item at a time; o_done strobes one cycle with the result, which cannot be stalled.
// A clear sweeps every count table entry, and a draw reads the table once per cluster
// in its scan.
// busy falls as o_done rises, so the next item may be taken at the edge ending o_done.
// Reset (i_rst_n low, synchronous) restores the registers and then sweeps the count
// memory to zero with busy high; config writes are still taken.
module pitman_yor_urn_sampler import pyu_pkg::*; #(
    parameter int MAX_CLUSTERS     = DEF_MAX_CLUSTERS,
    parameter int MAX_OBSERVATIONS = DEF_MAX_OBSERVATIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [LABEL_W-1:0]  i_seed_label,
    input  logic [UNI_W-1:0]    i_uniform,
    input  logic                i_cfg_we,
    input  logic [CFG_A_W-1:0]  i_cfg_addr,
    input  logic [CFG_D_W-1:0]  i_cfg_wdata,
    output logic                o_done,
    output logic [LABEL_W-1:0]  o_drawn_label,
    output logic                o_opened_cluster,
    output logic [STATUS_W-1:0] o_status
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pyu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    pyu_dp #(
        .MAX_CLUSTERS     (MAX_CLUSTERS),
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_seed_label     (i_seed_label),
        .i_uniform        (i_uniform),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_done           (o_done),
        .o_drawn_label    (o_drawn_label),
        .o_opened_cluster (o_opened_cluster),
        .o_status         (o_status)
    );

endmodule

// ===== tb/sv/pitman_yor_urn_sampler_tb.sv =====
`timescale 1ns / 1ps
module pitman_yor_urn_sampler_tb;
    import pyu_pkg::*;

    localparam int MAX_CL     = DEF_MAX_CLUSTERS;
    localparam int MAX_OBS    = DEF_MAX_OBSERVATIONS;
    localparam int SETTLE     = 4;
    localparam int WATCHDOG   = 4000;
    localparam int DRAIN_WAIT = 300;

    typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind          kind;
        t_command           cmd;
        logic [LABEL_W-1:0] label;
        logic [UNI_W-1:0]   uni;
        t_cfg_addr          addr;
        logic [CFG_D_W-1:0] data;
    } t_job;

    typedef struct {
        logic [LABEL_W-1:0] label;
        logic               opened;
        t_status            status;
    } t_draw_result;

    logic                i_clk;
    logic                i_rst_n          = 1'b0;
    logic                start            = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    i_command        = '0;
    logic [LABEL_W-1:0]  i_seed_label     = '0;
    logic [UNI_W-1:0]    i_uniform        = '0;
    logic                i_cfg_we         = 1'b0;
    logic [CFG_A_W-1:0]  i_cfg_addr       = '0;
    logic [CFG_D_W-1:0]  i_cfg_wdata      = '0;
    logic                o_done;
    logic [LABEL_W-1:0]  o_drawn_label;
    logic                o_opened_cluster;
    logic [STATUS_W-1:0] o_status;

    pitman_yor_urn_sampler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_seed_label    (i_seed_label),
        .i_uniform       (i_uniform),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_drawn_label   (o_drawn_label),
        .o_opened_cluster(o_opened_cluster),
        .o_status        (o_status)
    );

    // urn mirror
    logic [16:0]       urn_counts [MAX_CL];
    logic [8:0]        urn_clusters;
    logic [16:0]       urn_obs;
    logic [CONC_W-1:0] urn_conc;
    logic [DISC_W-1:0] urn_disc;

    t_job         jobs [$];
    t_job         cur_job;
    t_draw_result result_q [$];
    int           n_sent = 0;
    int           n_done = 0;
    int           errors = 0;
    int           gap_left;
    int           burst_left;
    int           idle_cycles;
    int           stall_cycles = 0;

    function automatic void urn_empty();
        foreach (urn_counts[i]) urn_counts[i] = '0;
        urn_clusters = '0;
        urn_obs      = '0;
    endfunction

    function automatic void urn_write_reg(t_cfg_addr addr, logic [CFG_D_W-1:0] data);
        case (addr)
            REG_CONC: urn_conc = data[CONC_W-1:0];
            REG_DISC: urn_disc = data[DISC_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_draw_result urn_apply(t_job it);
        t_draw_result r;
        longint       bound;
        longint       run;
        int           k;
        bit           hit;
        r = '{label: '0, opened: 1'b0, status: ST_OK};
        case (it.cmd)
            CMD_CLEAR: urn_empty();
            CMD_SEED: begin
                r.label = it.label;
                if (int'(it.label) >= MAX_CL) begin
                    r.status = ST_BAD_LABEL;
                end else if (urn_obs >= MAX_OBS) begin
                    r.status = ST_FULL;
                end else begin
                    urn_counts[it.label] = urn_counts[it.label] + 17'd1;
                    urn_obs = urn_obs + 17'd1;
                    if (urn_clusters < int'(it.label) + 1)
                        urn_clusters = 9'(it.label) + 9'd1;
                end
            end
            CMD_DRAW: begin
                if (urn_obs >= MAX_OBS) begin
                    r.status = ST_FULL;
                end else begin
                    // threshold u*(total+theta) in 2^-32 units
                    bound = longint'(it.uni) * (longint'(urn_obs) * 65536 + longint'(urn_conc));
                    run = 0;
                    hit = 1'b0;
                    k = 0;
                    while (k < urn_clusters && !hit) begin
                        run += longint'(urn_counts[k]) * 65536 - longint'(urn_disc);
                        if (run * 65536 > bound) hit = 1'b1;
                        else k++;
                    end
                    if (hit) begin
                        urn_counts[k] = urn_counts[k] + 17'd1;
                        urn_obs = urn_obs + 17'd1;
                        r.label = k[LABEL_W-1:0];
                    end else if (urn_clusters >= MAX_CL) begin
                        r.status = ST_FULL;
                    end else begin
                        urn_counts[urn_clusters[LABEL_W-1:0]] = 17'd1;
                        r.label = urn_clusters[LABEL_W-1:0];
                        r.opened = 1'b1;
                        urn_clusters = urn_clusters + 9'd1;
                        urn_obs = urn_obs + 17'd1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void push_item(t_command cmd, logic [LABEL_W-1:0] label,
                                      logic [UNI_W-1:0] uni);
        t_job j;
        j = '{kind: JOB_ITEM, cmd: cmd, label: label, uni: uni,
              addr: REG_CONC, data: '0};
        jobs.insert(jobs.size(), j);
    endfunction

    function automatic void push_cfg(t_cfg_addr addr, logic [CFG_D_W-1:0] data);
        t_job j;
        j = '{kind: JOB_CFG, cmd: CMD_NOP, label: '0, uni: '0,
              addr: addr, data: data};
        jobs.insert(jobs.size(), j);
    endfunction

    function automatic void push_drain();
        t_job j;
        j = '{kind: JOB_DRAIN, cmd: CMD_NOP, label: '0, uni: '0,
              addr: REG_CONC, data: '0};
        jobs.insert(jobs.size(), j);
    endfunction

    task automatic flag(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: items go out in bursts; config writes and drains wait for an idle block
    always @(posedge i_clk) begin : drive_items
        logic took;
        logic next_start;
        logic next_we;
        t_job head;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_we    <= 1'b0;
            gap_left    = 0;
            burst_left  = 1;
            idle_cycles = 0;
            urn_empty();
            urn_conc = 24'd65536;
            urn_disc = '0;
        end else begin
            took    = start && !busy;
            next_we = 1'b0;
            if (took) begin
                result_q.insert(result_q.size(), urn_apply(cur_job));
                n_sent <= n_sent + 1;
            end
            if (!start && !busy && n_sent == n_done) idle_cycles++;
            else idle_cycles = 0;
            if (!start || took) begin
                next_start = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (jobs.size() > 0) begin
                    if (jobs[0].kind == JOB_ITEM) begin
                        cur_job = jobs.pop_front();
                        next_start = 1'b1;
                        i_command    <= cur_job.cmd;
                        i_seed_label <= cur_job.label;
                        i_uniform    <= cur_job.uni;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 40);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                            if ($urandom_range(0, 19) == 0) gap_left = 40;
                        end
                    end else if (idle_cycles >= SETTLE) begin
                        head = jobs.pop_front();
                        if (head.kind == JOB_CFG) begin
                            next_we = 1'b1;
                            i_cfg_addr  <= head.addr;
                            i_cfg_wdata <= head.data;
                            urn_write_reg(head.addr, head.data);
                        end
                        idle_cycles = 0;
                    end
                end
                start <= next_start;
            end
            i_cfg_we <= next_we;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_draw_result want;
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                flag("result with no item outstanding");
            end else begin
                want = result_q.pop_front();
                n_done <= n_done + 1;
                if (o_drawn_label !== want.label)
                    flag($sformatf("o_drawn_label got %0d want %0d", o_drawn_label, want.label));
                if (o_opened_cluster !== want.opened)
                    flag($sformatf("o_opened_cluster got %0b want %0b",
                                   o_opened_cluster, want.opened));
                if (o_status !== want.status)
                    flag($sformatf("o_status got %0d want %0d", o_status, want.status));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int                 sel;
        logic [CONC_W-1:0]  conc_pick [6];
        logic [DISC_W-1:0]  disc_pick [6];
        logic [LABEL_W-1:0] lbl;

        // directed
        push_cfg(REG_CONC, 24'd65536);
        push_cfg(REG_DISC, 24'd0);
        push_item(CMD_DRAW, 8'h00, 16'h0000);   // empty urn opens cluster 0
        push_item(CMD_DRAW, 8'hFF, 16'hFFFF);
        push_item(CMD_DRAW, 8'h00, 16'h0000);
        push_item(CMD_SEED, 8'hFF, 16'h0000);   // skips up to the last cluster
        push_item(CMD_SEED, 8'hAA, 16'hFFFF);
        push_item(CMD_NOP,  8'h55, 16'hAAAA);
        push_cfg(REG_DISC, 24'hFFFFFF);          // upper data bits are ignored
        push_cfg(REG_CONC, 24'd0);
        push_item(CMD_DRAW, 8'h00, 16'hFFFF);   // table full, no room to open
        push_item(CMD_DRAW, 8'hAA, 16'h5555);
        push_item(CMD_SEED, 8'h55, 16'h5555);
        push_item(CMD_CLEAR, 8'hFF, 16'hFFFF);
        push_item(CMD_DRAW, 8'h00, 16'h0000);
        push_item(CMD_DRAW, 8'h00, 16'hFFFF);
        push_cfg(REG_CONC, 24'hFFFFFF);
        push_cfg(REG_DISC, 24'h008000);
        push_item(CMD_DRAW, 8'h00, 16'hFFFF);
        push_item(CMD_DRAW, 8'h00, 16'h0001);
        push_item(CMD_SEED, 8'h00, 16'h0000);
        push_item(CMD_NOP,  8'h00, 16'h0000);
        push_item(CMD_CLEAR, 8'h00, 16'h0000);
        push_item(CMD_DRAW, 8'h00, 16'h8000);

        // random phases over a spread of settings
        conc_pick = '{24'd0, 24'd65536, 24'hFFFFFF, 24'($urandom), 24'($urandom_range(0, 262143)),
                      24'd1};
        disc_pick = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0000, 16'hFFFF, 16'($urandom)};
        for (int p = 0; p < 6; p++) begin
            push_cfg(REG_CONC, conc_pick[p]);
            push_cfg(REG_DISC, {8'($urandom), disc_pick[p]});
            push_item(CMD_CLEAR, 8'($urandom), 16'($urandom));
            for (int n = 0; n < 200; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 4) begin
                    push_item(CMD_CLEAR, 8'($urandom), 16'($urandom));
                end else if (sel < 8) begin
                    push_item(CMD_NOP, 8'($urandom), 16'($urandom));
                end else if (sel < 30) begin
                    // mostly low labels so draws stay short
                    lbl = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
                    push_item(CMD_SEED, lbl, 16'($urandom));
                end else begin
                    push_item(CMD_DRAW, 8'($urandom), 16'($urandom));
                end
                if ($urandom_range(0, 99) == 0) push_drain();
            end
        end

        // short tail under fresh settings, with one full drain
        push_cfg(REG_CONC, 24'($urandom));
        push_cfg(REG_DISC, 24'($urandom));
        push_item(CMD_CLEAR, 8'h00, 16'h0000);
        for (int n = 0; n < 10; n++)
            push_item(CMD_SEED, 8'($urandom_range(0, 3)), 16'($urandom));
        for (int n = 0; n < 10; n++)
            push_item(CMD_DRAW, 8'($urandom), 16'($urandom));
        push_drain();
        push_item(CMD_SEED, 8'($urandom_range(0, 3)), 16'($urandom));
        push_item(CMD_DRAW, 8'($urandom), 16'($urandom));
        push_item(CMD_CLEAR, 8'($urandom), 16'($urandom));
        push_item(CMD_DRAW, 8'($urandom), 16'($urandom));

        do @(negedge i_clk);
        while (jobs.size() != 0 || start || n_sent != n_done);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
